/* rtl/nnm_pkg.sv */
`default_nettype none

package nnm_pkg;

  // parse phases
  localparam logic [2:0] PH_LETTER   = 3'd0;
  localparam logic [2:0] PH_ACCID    = 3'd1;
  localparam logic [2:0] PH_PRESIGN  = 3'd2;
  localparam logic [2:0] PH_POSTSIGN = 3'd3;
  localparam logic [2:0] PH_DIGITS   = 3'd4;
  localparam logic [2:0] PH_DONE     = 3'd5;

  // result status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_LETTER = 3'd1;
  localparam logic [2:0] ST_NO_ACCID   = 3'd2;
  localparam logic [2:0] ST_NO_OCTAVE  = 3'd3;
  localparam logic [2:0] ST_RANGE      = 3'd4;

  // pitch class marker for a character that is not a letter a-g
  localparam logic [3:0] PC_NONE = 4'hF;

  // highest octave and note that are in range, and the saturated octave value
  localparam logic [3:0] OCT_MAX  = 4'd10;
  localparam logic [3:0] OCT_SAT  = 4'd11;
  localparam logic [7:0] NOTE_MAX = 8'h7F;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [6:0] midi_note;
    logic [2:0] status;
  } out_item_t;

  typedef struct packed {
    logic [2:0] parse_phase;
    logic [3:0] pitch_class;
    logic       negative_sign;
    logic [3:0] octave_value;
    logic       saw_digit;
    logic [2:0] error_code;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    parse_phase:   PH_LETTER,
    pitch_class:   4'd0,
    negative_sign: 1'b0,
    octave_value:  4'd0,
    saw_digit:     1'b0,
    error_code:    ST_OK
  };

endpackage

`default_nettype wire

/* rtl/nnm_parse.sv */
`default_nettype none

module nnm_parse import nnm_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      step_i,
  input  wire in_item_t  item_i,
  output out_item_t      result_o
);

  parse_state_t state_q, state_d, state_n;

  logic [7:0] c;
  logic [7:0] upper;
  logic [3:0] letter_pc;
  logic       is_blank, is_digit;
  logic       run_oct;
  logic [2:0] oct_phase;
  logic [6:0] digit_sum;
  logic [7:0] note_sum;

  assign c = item_i.char_code;

  // character classes
  always_comb begin
    upper    = (c >= 8'h61 && c <= 8'h7A) ? (c - 8'd32) : c;
    is_blank = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    is_digit = (c >= 8'h30 && c <= 8'h39);
    case (upper)
      8'h43:   letter_pc = 4'd0;
      8'h44:   letter_pc = 4'd2;
      8'h45:   letter_pc = 4'd4;
      8'h46:   letter_pc = 4'd5;
      8'h47:   letter_pc = 4'd7;
      8'h41:   letter_pc = 4'd9;
      8'h42:   letter_pc = 4'd11;
      default: letter_pc = PC_NONE;
    endcase
  end

  // saturating octave accumulate
  assign digit_sum = {3'b000, state_q.octave_value} * 7'd10 + {3'b000, c[3:0]};

  // next parse state for this character
  always_comb begin
    state_n   = state_q;
    run_oct   = 1'b0;
    oct_phase = state_q.parse_phase;
    case (state_q.parse_phase)
      PH_LETTER: begin
        if (letter_pc == PC_NONE) begin
          state_n.error_code  = ST_BAD_LETTER;
          state_n.parse_phase = PH_DONE;
        end else begin
          state_n.pitch_class = letter_pc;
          state_n.parse_phase = PH_ACCID;
        end
      end
      PH_ACCID: begin
        if (c == 8'h23) begin
          if (state_q.pitch_class == 4'd11 || state_q.pitch_class == 4'd4) begin
            state_n.error_code  = ST_NO_ACCID;
            state_n.parse_phase = PH_DONE;
          end else begin
            state_n.pitch_class = state_q.pitch_class + 4'd1;
            state_n.parse_phase = PH_PRESIGN;
          end
        end else if (c == 8'h62) begin
          if (state_q.pitch_class == 4'd0 || state_q.pitch_class == 4'd5) begin
            state_n.error_code  = ST_NO_ACCID;
            state_n.parse_phase = PH_DONE;
          end else begin
            state_n.pitch_class = state_q.pitch_class - 4'd1;
            state_n.parse_phase = PH_PRESIGN;
          end
        end else begin
          state_n.parse_phase = PH_PRESIGN;
          run_oct             = 1'b1;
          oct_phase           = PH_PRESIGN;
        end
      end
      default: begin
        run_oct = 1'b1;
      end
    endcase

    // blanks, sign and octave digits
    if (run_oct) begin
      if (oct_phase == PH_PRESIGN) begin
        if (is_blank) begin
          state_n.parse_phase = PH_PRESIGN;
        end else if (c == 8'h2B) begin
          state_n.parse_phase = PH_POSTSIGN;
        end else if (c == 8'h2D) begin
          state_n.negative_sign = 1'b1;
          state_n.parse_phase   = PH_POSTSIGN;
        end else if (is_digit) begin
          state_n.octave_value = (digit_sum > 7'd11) ? OCT_SAT : digit_sum[3:0];
          state_n.saw_digit    = 1'b1;
          state_n.parse_phase  = PH_DIGITS;
        end else begin
          state_n.parse_phase = PH_DONE;
        end
      end else if (oct_phase == PH_POSTSIGN || oct_phase == PH_DIGITS) begin
        if (is_digit) begin
          state_n.octave_value = (digit_sum > 7'd11) ? OCT_SAT : digit_sum[3:0];
          state_n.saw_digit    = 1'b1;
          state_n.parse_phase  = PH_DIGITS;
        end else begin
          state_n.parse_phase = PH_DONE;
        end
      end
    end
  end

  // note number: pitch class plus twelve times octave
  assign note_sum = {4'd0, state_n.pitch_class}
                  + {1'b0, state_n.octave_value, 3'b000}
                  + {2'b00, state_n.octave_value, 2'b00};

  // result from the updated state, first error wins
  always_comb begin
    result_o.midi_note = 7'd0;
    if (state_n.error_code != ST_OK) begin
      result_o.status = state_n.error_code;
    end else if (!state_n.saw_digit) begin
      result_o.status = ST_NO_OCTAVE;
    end else if ((state_n.negative_sign && state_n.octave_value != 4'd0) ||
                 state_n.octave_value > OCT_MAX) begin
      result_o.status = ST_RANGE;
    end else if (note_sum > NOTE_MAX) begin
      result_o.status = ST_RANGE;
    end else begin
      result_o.status    = ST_OK;
      result_o.midi_note = note_sum[6:0];
    end
  end

  // a finished name starts the parse over
  assign state_d = item_i.is_last ? PARSE_RESET : state_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PARSE_RESET;
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/nnm_out_reg.sv */
`default_nettype none

module nnm_out_reg import nnm_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      load_i,
  input  wire out_item_t item_i,
  output logic           space_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  logic      valid_q;
  out_item_t item_q;

  // free when empty or being drained this cycle
  assign space_o     = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/note_name_to_midi_parser_unit.sv */
// Note name parser: takes one ASCII character per item (letter A-G, optional
// '#' or 'b', optional blanks and sign, decimal octave) and gives one item with
// the MIDI note number and a status on the character marked is_last. A
// character item is taken every cycle; it is held in the input register, is
// parsed against the running state and, if it is the last one, its result
// is loaded into the output register. Only a result waiting in the output
// register while another last character arrives holds the input back.
`default_nettype none

module note_name_to_midi_parser_unit import nnm_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_space;
  logic      advance;
  out_item_t result;

  // the held character moves on unless its result has nowhere to go
  assign advance    = in_valid_q && (!in_item_q.is_last || out_space);
  assign in_ready_o = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
  end

  // parse state and result logic
  nnm_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_item_q),
    .result_o (result)
  );

  // result register
  nnm_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && in_item_q.is_last),
    .item_i      (result),
    .space_o     (out_space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

/* tb/tb_note_name_to_midi_parser_unit.sv */
`default_nettype none

module tb_note_name_to_midi_parser_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import nnm_pkg::*;

  // cycles without any accepted item before the run is declared hung
  localparam int QUIET_LIMIT = 1500;
  localparam int HOLD_CYCLES = 300;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  // predicted parse state and pending note results
  parse_state_t parser_now = PARSE_RESET;
  out_item_t    notes_due[$];
  logic [7:0]   name_chars[$];

  int  mismatches = 0;
  int  chars_sent = 0;
  int  hold_left = 0;
  bit  src_idle = 1'b1;
  bit  sink_idle = 1'b1;

  note_name_to_midi_parser_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // advance the predicted parse by one character
  task automatic parse_char(input in_item_t it);
    logic [7:0] c;
    logic [7:0] up;
    logic [3:0] letter_pc;
    int         octv;
    int         note;
    out_item_t  res;
    c = it.char_code;
    if (parser_now.parse_phase == PH_LETTER) begin
      up = (c >= "a" && c <= "z") ? c - 8'd32 : c;
      case (up)
        "C": letter_pc = 4'd0;
        "D": letter_pc = 4'd2;
        "E": letter_pc = 4'd4;
        "F": letter_pc = 4'd5;
        "G": letter_pc = 4'd7;
        "A": letter_pc = 4'd9;
        "B": letter_pc = 4'd11;
        default: letter_pc = PC_NONE;
      endcase
      if (letter_pc == PC_NONE) begin
        parser_now.error_code = ST_BAD_LETTER;
        parser_now.parse_phase = PH_DONE;
      end else begin
        parser_now.pitch_class = letter_pc;
        parser_now.parse_phase = PH_ACCID;
      end
    end else if (parser_now.parse_phase == PH_ACCID && (c == "#" || c == "b")) begin
      // sharp or flat, with the four that do not exist rejected
      if ((c == "#" && (parser_now.pitch_class == 4'd11 || parser_now.pitch_class == 4'd4)) ||
          (c == "b" && (parser_now.pitch_class == 4'd0 || parser_now.pitch_class == 4'd5))) begin
        parser_now.error_code = ST_NO_ACCID;
        parser_now.parse_phase = PH_DONE;
      end else begin
        parser_now.pitch_class = (c == "#") ? parser_now.pitch_class + 4'd1
                                            : parser_now.pitch_class - 4'd1;
        parser_now.parse_phase = PH_PRESIGN;
      end
    end else begin
      if (parser_now.parse_phase == PH_ACCID) parser_now.parse_phase = PH_PRESIGN;
      // blanks, sign and octave digits
      if (parser_now.parse_phase inside {PH_PRESIGN, PH_POSTSIGN, PH_DIGITS}) begin
        if (c >= "0" && c <= "9") begin
          octv = parser_now.octave_value * 10 + (c - "0");
          parser_now.octave_value = (octv > OCT_SAT) ? OCT_SAT : octv[3:0];
          parser_now.saw_digit = 1'b1;
          parser_now.parse_phase = PH_DIGITS;
        end else if (parser_now.parse_phase == PH_PRESIGN &&
                     (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D))) begin
          // blanks before the sign are skipped
        end else if (parser_now.parse_phase == PH_PRESIGN && c == "+") begin
          parser_now.parse_phase = PH_POSTSIGN;
        end else if (parser_now.parse_phase == PH_PRESIGN && c == "-") begin
          parser_now.negative_sign = 1'b1;
          parser_now.parse_phase = PH_POSTSIGN;
        end else begin
          parser_now.parse_phase = PH_DONE;
        end
      end
    end

    // result on the last character, then back to the start of a name
    if (it.is_last) begin
      res = '0;
      if (parser_now.error_code != ST_OK) begin
        res.status = parser_now.error_code;
      end else if (!parser_now.saw_digit) begin
        res.status = ST_NO_OCTAVE;
      end else if ((parser_now.negative_sign && parser_now.octave_value != 4'd0) ||
                   parser_now.octave_value > OCT_MAX) begin
        res.status = ST_RANGE;
      end else begin
        note = parser_now.pitch_class + 12 * parser_now.octave_value;
        if (note > NOTE_MAX) begin
          res.status = ST_RANGE;
        end else begin
          res.status = ST_OK;
          res.midi_note = note[6:0];
        end
      end
      notes_due.push_back(res);
      parser_now = PARSE_RESET;
    end
  endtask

  // offer one character and wait until it is taken
  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    in_item_t it;
    gap = src_idle ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    it.char_code = c;
    it.is_last = last;
    in_item_i <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    parse_char(it);
    chars_sent++;
  endtask

  task automatic send_name();
    foreach (name_chars[i]) send_char(name_chars[i], i == name_chars.size() - 1);
  endtask

  task automatic send_text(input string s);
    name_chars.delete();
    for (int i = 0; i < s.len(); i++) name_chars.push_back(s[i]);
    send_name();
  endtask

  // mostly well-formed names with random content, some noise and truncation
  task automatic build_name();
    string letters;
    int kind;
    int n;
    int blank;
    int r;
    letters = "CDEFGAB";
    name_chars.delete();
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      n = $urandom_range(1, 5);
      repeat (n) name_chars.push_back(8'($urandom_range(0, 255)));
    end else begin
      name_chars.push_back(letters[$urandom_range(0, 6)] + ($urandom_range(0, 1) ? 8'd32 : 8'd0));
      r = $urandom_range(0, 2);
      if (r == 1) name_chars.push_back("#");
      if (r == 2) name_chars.push_back("b");
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 2);
        repeat (n) begin
          blank = $urandom_range(8, 13);
          name_chars.push_back(blank == 8 ? 8'h20 : 8'(blank));
        end
      end
      r = $urandom_range(0, 3);
      if (r == 1) name_chars.push_back("+");
      if (r == 2) name_chars.push_back("-");
      r = $urandom_range(0, 7);
      if (r == 0) begin
        repeat (3) name_chars.push_back(8'("0" + $urandom_range(0, 9)));
      end else if (r < 3) begin
        name_chars.push_back("1");
        name_chars.push_back(8'("0" + $urandom_range(0, 9)));
      end else begin
        name_chars.push_back(8'("0" + $urandom_range(0, 9)));
      end
      if ($urandom_range(0, 3) == 0) name_chars.push_back(8'($urandom_range(0, 255)));
      // broken name: cut at a random point
      if (kind == 2) begin
        n = $urandom_range(1, name_chars.size());
        while (name_chars.size() > n) void'(name_chars.pop_back());
      end
    end
  endtask

  task automatic test_directed();
    send_text("C0");
    send_text("g10");
    send_text("G#10");
    send_text("Bb-0");
    send_text("E#");
    send_text("Cb");
    send_text("H");
    send_char(8'h00, 1'b1);
    send_char("A", 1'b0);
    send_char(8'hFF, 1'b1);
    send_text("D\t+7");
    send_text("a-3");
    send_text("f99");
  endtask

  task automatic test_random_names();
    int stop_at;
    src_idle = 1'b1;
    sink_idle = 1'b1;
    stop_at = chars_sent + 260;
    while (chars_sent < stop_at) begin
      build_name();
      send_name();
    end
  endtask

  task automatic test_back_to_back();
    int stop_at;
    src_idle = 1'b0;
    sink_idle = 1'b0;
    stop_at = chars_sent + 50;
    while (chars_sent < stop_at) begin
      build_name();
      send_name();
    end
    sink_idle = 1'b1;
    stop_at = chars_sent + 50;
    while (chars_sent < stop_at) begin
      build_name();
      send_name();
    end
  endtask

  // receiver holds off while one-character names keep coming
  task automatic test_output_backpressure();
    src_idle = 1'b0;
    sink_idle = 1'b0;
    hold_left = HOLD_CYCLES;
    repeat (40) send_char(8'($urandom_range(0, 255)), 1'b1);
    sink_idle = 1'b1;
  endtask

  // receiver ready, with random stalls and the long hold-off
  initial begin : receiver
    int wait_left;
    out_ready_i = 1'b0;
    wait_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) wait_left = sink_idle ? $urandom_range(0, 18) : 0;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (wait_left > 0) begin
        wait_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic report_bad(input string why, input out_item_t want, input out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch (%s): expected note %0d status %0d, got note %0d status %0d",
               why, want.midi_note, want.status, got.midi_note, got.status);
  endtask

  // compare each result item with the oldest prediction
  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (notes_due.size() == 0) begin
        report_bad("no item expected", '0, out_item_o);
      end else begin
        want = notes_due.pop_front();
        if (out_item_o.midi_note !== want.midi_note) report_bad("midi_note", want, out_item_o);
        if (out_item_o.status !== want.status) report_bad("status", want, out_item_o);
      end
    end
  end

  // hang detection
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    in_valid_i = 1'b0;
    in_item_i = '0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_names();
    test_back_to_back();
    test_output_backpressure();
    in_valid_i <= 1'b0;
    // drain the remaining results
    while (notes_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
